@@ hdl/time_window_moving_average_macros.svh @@
// Assertion macros shared by the moving-average RTL.
`ifndef TIME_WINDOW_MOVING_AVERAGE_MACROS_SVH
`define TIME_WINDOW_MOVING_AVERAGE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define TWMA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define TWMA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define TWMA_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define TWMA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

@@ hdl/twma_pkg.sv @@
// Types and constants shared by the moving-average block.
`default_nettype none

package twma_pkg;

   // Window entry layout, lowest bits first: time, power, heart rate.
   localparam int TIME_W  = 27;
   localparam int PWR_W   = 12;
   localparam int HR_W    = 8;
   localparam int ENTRY_W = TIME_W + PWR_W + HR_W;

   localparam int SEC_W   = 17;
   localparam int WIN_W   = 10;
   localparam int AVGP_W  = 16;
   localparam int AVGH_W  = 12;

   // Quotient bits produced by the serial divider, and its step counter width.
   localparam int QUOT_W  = 16;
   localparam int STEP_W  = $clog2(QUOT_W);

   localparam logic [WIN_W-1:0] WINDOW_RESET = 10'd30;
   localparam logic [WIN_W-1:0] MS_PER_SEC   = 10'd1000;

   // Request kinds carried on tuser.
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LIMIT,
      ST_EV_READ,
      ST_EV_CHECK,
      ST_DIV,
      ST_RESULT
   } twma_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } twma_div_status_type;

endpackage

`default_nettype wire

@@ hdl/twma_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module twma_ram #(
   parameter int WIDTH = 47,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/twma_div.sv @@
// Two-lane restoring divider, one quotient bit per lane per cycle.
`default_nettype none

module twma_div #(
   parameter int CNT_W = 9
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic [1:0][CNT_W+twma_pkg::QUOT_W-1:0]  dividend,
   input  logic [CNT_W-1:0]                        divisor,
   output logic [1:0][twma_pkg::QUOT_W-1:0]        quotient,
   output twma_pkg::twma_div_status_type           status
);

   localparam int QW = twma_pkg::QUOT_W;

   // The quotient is known to fit QW bits, so the bits above the low QW of
   // the dividend are already below the divisor and seed the remainder.
   logic [1:0][CNT_W-1:0] rem_ff, rem_in;
   logic [1:0][QW-1:0]    dvd_ff, dvd_in;
   logic [CNT_W-1:0]      dsr_ff, dsr_in;
   logic [twma_pkg::STEP_W-1:0] step_ff, step_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;

   logic [CNT_W:0] trial;
   logic           ge;

   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = '0;
      ge      = 1'b0;
      if (start) begin
         for (int i = 0; i < 2; i++) begin
            rem_in[i] = dividend[i][CNT_W+QW-1:QW];
            dvd_in[i] = dividend[i][QW-1:0];
         end
         dsr_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         for (int i = 0; i < 2; i++) begin
            trial     = {rem_ff[i], dvd_ff[i][QW-1]};
            ge        = (trial >= {1'b0, dsr_ff});
            rem_in[i] = ge ? CNT_W'(trial - {1'b0, dsr_ff}) : trial[CNT_W-1:0];
            dvd_in[i] = {dvd_ff[i][QW-2:0], ge};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == twma_pkg::STEP_W'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign quotient    = dvd_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

@@ hdl/time_window_moving_average.sv @@
// Top level: time-windowed moving average of power and heart-rate samples.
// Sample request: one per cycle while idle; written to the window RAM at acceptance
// unless the window is full (then dropped, overflow set). Tick request: time limit set,
//   each eviction is a RAM read plus a check, the mean is a 16-step serial divide.
// Early tick: straight to result; empty window: no divide. One tick in flight at a time.
// Reset clears the window pointers, sums, counters and flags; RAM is not cleared.
`default_nettype none

`include "time_window_moving_average_macros.svh"

module time_window_moving_average #(
   parameter int WINDOW_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // sample_time_ms[26:0], sample_power[39:27], sample_hr[48:40]
   input  logic        req_tuser,  // opcode[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // second_index[16:0], avg_power[32:17], avg_hr[44:33],
                                   // peak_average[60:45], overflow_seen[61]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [9:0]  csr_data    // window_secs
);

   localparam int AW     = $clog2(WINDOW_DEPTH);
   localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
   localparam int PSUM_W = twma_pkg::PWR_W + CNT_W;
   localparam int HSUM_W = twma_pkg::HR_W + CNT_W;
   localparam int DIV_W  = CNT_W + twma_pkg::QUOT_W;
   localparam int HPAD   = DIV_W - HSUM_W - 4;
   localparam int TW     = twma_pkg::TIME_W;
   localparam int PW     = twma_pkg::PWR_W;
   localparam int HW     = twma_pkg::HR_W;

   twma_pkg::twma_state_type state_ff, state_in;

   logic [AW-1:0]    head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PSUM_W-1:0] psum_ff, psum_in;
   logic [HSUM_W-1:0] hsum_ff, hsum_in;
   logic [twma_pkg::SEC_W-1:0] second_ff, second_in;
   logic [twma_pkg::AVGP_W-1:0] peak_ff, peak_in;
   logic overflow_ff, overflow_in;
   logic [twma_pkg::WIN_W-1:0] window_ff, window_in;
   logic [TW-1:0] limit_ff, limit_in;
   logic [twma_pkg::AVGP_W-1:0] ap_ff, ap_in;
   logic [twma_pkg::AVGH_W-1:0] ah_ff, ah_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff, rsp_data_in;

   // control decoded from state
   logic rd_en, div_start, load_rsp, evict, push_en, tick_accept;

   logic req_fire, is_tick, early, fifo_full, old_entry;
   logic [PW-1:0] pwr_clamped;
   logic [HW-1:0] hr_clamped;
   logic [CNT_W:0] tail_sum;
   logic [AW-1:0]  tail_addr;
   logic [twma_pkg::SEC_W-1:0] sec_diff;
   logic [TW-1:0] limit_prod;
   logic [twma_pkg::AVGP_W-1:0] peak_next;

   logic [twma_pkg::ENTRY_W-1:0] wr_entry, rd_entry;
   logic [1:0][DIV_W-1:0] div_dividend;
   logic [1:0][twma_pkg::QUOT_W-1:0] div_quotient;
   twma_pkg::twma_div_status_type div_status;

   assign req_tready = (state_ff == twma_pkg::ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign is_tick    = (req_tuser == twma_pkg::OP_TICK);
   assign early      = (second_ff < {{(twma_pkg::SEC_W - twma_pkg::WIN_W){1'b0}}, window_ff});
   assign fifo_full  = (count_ff == CNT_W'(WINDOW_DEPTH));
   assign old_entry  = (rd_entry[TW-1:0] < limit_ff);
   assign csr_ready  = 1'b1;

   // negative readings clamp to zero
   assign pwr_clamped = req_tdata[39] ? '0 : req_tdata[38:27];
   assign hr_clamped  = req_tdata[48] ? '0 : req_tdata[47:40];
   assign wr_entry    = {hr_clamped, pwr_clamped, req_tdata[26:0]};

   assign tail_sum  = {{(CNT_W + 1 - AW){1'b0}}, head_ff} + {1'b0, count_ff};
   assign tail_addr = (tail_sum >= (CNT_W + 1)'(WINDOW_DEPTH))
                    ? AW'(tail_sum - (CNT_W + 1)'(WINDOW_DEPTH))
                    : tail_sum[AW-1:0];

   assign sec_diff   = second_ff - {{(twma_pkg::SEC_W - twma_pkg::WIN_W){1'b0}}, window_ff};
   assign limit_prod = {{(TW - twma_pkg::SEC_W){1'b0}}, sec_diff}
                     * {{(TW - twma_pkg::WIN_W){1'b0}}, twma_pkg::MS_PER_SEC};

   always_comb begin
      peak_next = peak_ff;
      if (ap_ff > peak_next) begin
         peak_next = ap_ff;
      end
      if ({4'b0, ah_ff} > peak_next) begin
         peak_next = {4'b0, ah_ff};
      end
   end

   assign div_dividend[0] = {psum_ff, 4'b0};
   assign div_dividend[1] = {{HPAD{1'b0}}, hsum_ff, 4'b0};

   twma_ram #(
      .WIDTH (twma_pkg::ENTRY_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (push_en & ~fifo_full),
      .wr_addr (tail_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (head_ff),
      .rd_data (rd_entry)
   );

   twma_div #(
      .CNT_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (count_ff),
      .quotient (div_quotient),
      .status   (div_status)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         twma_pkg::ST_IDLE: begin
            if (req_fire && is_tick) begin
               state_in = early ? twma_pkg::ST_RESULT : twma_pkg::ST_LIMIT;
            end
         end
         twma_pkg::ST_LIMIT: begin
            state_in = twma_pkg::ST_EV_READ;
         end
         twma_pkg::ST_EV_READ: begin
            state_in = (count_ff == '0) ? twma_pkg::ST_RESULT : twma_pkg::ST_EV_CHECK;
         end
         twma_pkg::ST_EV_CHECK: begin
            state_in = old_entry ? twma_pkg::ST_EV_READ : twma_pkg::ST_DIV;
         end
         twma_pkg::ST_DIV: begin
            if (div_status.done) begin
               state_in = twma_pkg::ST_RESULT;
            end
         end
         twma_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = twma_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = twma_pkg::ST_IDLE;
         end
      endcase
   end

   // control outputs
   always_comb begin
      rd_en       = 1'b0;
      div_start   = 1'b0;
      load_rsp    = 1'b0;
      evict       = 1'b0;
      push_en     = 1'b0;
      tick_accept = 1'b0;
      unique case (state_ff)
         twma_pkg::ST_IDLE: begin
            push_en     = req_fire && !is_tick;
            tick_accept = req_fire && is_tick;
         end
         twma_pkg::ST_LIMIT: begin
         end
         twma_pkg::ST_EV_READ: begin
            rd_en = (count_ff != '0);
         end
         twma_pkg::ST_EV_CHECK: begin
            evict     = old_entry;
            div_start = !old_entry;
         end
         twma_pkg::ST_DIV: begin
         end
         twma_pkg::ST_RESULT: begin
            load_rsp = !rsp_valid_ff || rsp_tready;
         end
         default: begin
         end
      endcase
   end

   // datapath
   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      psum_in      = psum_ff;
      hsum_in      = hsum_ff;
      second_in    = second_ff;
      peak_in      = peak_ff;
      overflow_in  = overflow_ff;
      window_in    = window_ff;
      limit_in     = limit_ff;
      ap_in        = ap_ff;
      ah_in        = ah_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;

      if (csr_valid) begin
         window_in = csr_data;
      end

      if (push_en) begin
         if (fifo_full) begin
            overflow_in = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
            psum_in  = psum_ff + {{(PSUM_W - PW){1'b0}}, pwr_clamped};
            hsum_in  = hsum_ff + {{(HSUM_W - HW){1'b0}}, hr_clamped};
         end
      end

      if (tick_accept) begin
         ap_in = '0;
         ah_in = '0;
      end

      if (state_ff == twma_pkg::ST_LIMIT) begin
         limit_in = limit_prod;
      end

      if (evict) begin
         psum_in  = psum_ff - {{(PSUM_W - PW){1'b0}}, rd_entry[TW+PW-1:TW]};
         hsum_in  = hsum_ff - {{(HSUM_W - HW){1'b0}}, rd_entry[TW+PW+HW-1:TW+PW]};
         head_in  = (head_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end

      if (div_status.done) begin
         ap_in = div_quotient[0];
         ah_in = div_quotient[1][twma_pkg::AVGH_W-1:0];
      end

      if (load_rsp) begin
         second_in    = second_ff + 1'b1;
         peak_in      = peak_next;
         rsp_valid_in = 1'b1;
         rsp_data_in  = {2'b0, overflow_ff, peak_next, ah_ff, ap_ff, second_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= twma_pkg::ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         psum_ff      <= '0;
         hsum_ff      <= '0;
         second_ff    <= '0;
         peak_ff      <= '0;
         overflow_ff  <= 1'b0;
         window_ff    <= twma_pkg::WINDOW_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         psum_ff      <= psum_in;
         hsum_ff      <= hsum_in;
         second_ff    <= second_in;
         peak_ff      <= peak_in;
         overflow_ff  <= overflow_in;
         window_ff    <= window_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      limit_ff    <= limit_in;
      ap_ff       <= ap_in;
      ah_ff       <= ah_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `TWMA_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(WINDOW_DEPTH), "window count above depth")
   `TWMA_ASSERT_NEXT(a_overflow_sticky, clock, reset, overflow_ff, overflow_ff, "overflow flag cleared")
   `TWMA_ASSERT_NOW(a_div_done_state, clock, reset, div_status.done, state_ff == twma_pkg::ST_DIV, "divider finished outside divide state")
   `TWMA_ASSERT_NOW(a_check_nonempty, clock, reset, state_ff == twma_pkg::ST_EV_CHECK, count_ff != '0, "eviction check on empty window")
   `TWMA_ASSERT_NEXT(a_second_step, clock, reset, load_rsp, second_ff == twma_pkg::SEC_W'($past(second_ff) + 1'b1), "second counter did not advance")

endmodule

`default_nettype wire
